// File: sv/hpq_pkg.sv
// shared constants and operation and status codes for the min-heap priority queue
`default_nettype none
package hpq_pkg;

    localparam int DEF_CAPACITY = 1024;
    localparam int DEF_KEY_BITS = 32;

    localparam int OP_W  = 2;
    localparam int KEY_W = 32;
    localparam int ST_W  = 2;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_PEEK   = 2'd2;

    localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

endpackage
`default_nettype wire

// File: sv/hpq_if.sv
// request and result channel interfaces of the min-heap priority queue
`default_nettype none
interface hpq_req_if;
    import hpq_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [KEY_W-1:0]  key;

    modport source (output valid, output operation, output key, input ready);
    modport sink   (input valid, input operation, input key, output ready);
endinterface

interface hpq_res_if #(
    parameter int CNT_W = 11
);
    import hpq_pkg::*;

    logic              valid;
    logic              ready;
    logic [ST_W-1:0]   status;
    logic [KEY_W-1:0]  top_key;
    logic              top_valid;
    logic [CNT_W-1:0]  count;

    modport source (output valid, output status, output top_key, output top_valid,
                    output count, input ready);
    modport sink   (input valid, input status, input top_key, input top_valid,
                    input count, output ready);
endinterface
`default_nettype wire

// File: sv/min_heap_priority_queue.sv
// min-heap priority queue top level: sift sequencer, sift-down compare unit and result register
// insert sifts the new key up with a parent read and a compare per level;
// remove sifts the last key down from the root: left read, right read, compare per level;
// peek and flagged items go straight to the root read that ends every operation
// one item at a time, held while the result register is full; one memory read port per cycle
// reset clears the element count and the handshake state; heap memory contents are not cleared
`default_nettype none
module min_heap_priority_queue #(
    parameter int CAPACITY = hpq_pkg::DEF_CAPACITY,
    parameter int KEY_BITS = hpq_pkg::DEF_KEY_BITS
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    hpq_req_if.sink   i_in,
    hpq_res_if.source o_out
);
    import hpq_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = AW + 2;
    localparam int SW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;

    typedef enum logic [9:0] {
        S_IDLE    = 10'b0000000001,
        S_UP_RD   = 10'b0000000010,
        S_UP_CMP  = 10'b0000000100,
        S_DN_LAST = 10'b0000001000,
        S_DN_RDL  = 10'b0000010000,
        S_DN_RDR  = 10'b0000100000,
        S_DN_CMP  = 10'b0001000000,
        S_TOP_RD  = 10'b0010000000,
        S_TOP_CAP = 10'b0100000000,
        S_DONE    = 10'b1000000000
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [AW-1:0]   r_pos, n_pos;
    logic [AW-1:0]   r_par, n_par;
    logic [SW-1:0]   r_key, n_key;
    logic [SW-1:0]   r_lval, n_lval;
    logic            r_rvalid, n_rvalid;
    logic [ST_W-1:0] r_status, n_status;
    logic [KEY_W-1:0] r_top, n_top;

    logic             r_out_valid;
    logic [ST_W-1:0]  r_out_status;
    logic [KEY_W-1:0] r_out_key;
    logic             r_out_tv;
    logic [CW-1:0]    r_out_cnt;

    logic            w_we;
    logic [AW-1:0]   w_waddr;
    logic [SW-1:0]   w_wdata;
    logic [AW-1:0]   w_raddr;
    logic [SW-1:0]   w_rdata;

    logic            w_acc;
    logic            w_load;
    logic [IW-1:0]   w_left;
    logic [IW-1:0]   w_right;
    logic [IW-1:0]   w_cnt_x;
    logic            w_pick_l;
    logic [SW-1:0]   w_best;
    logic            w_pick_r;

    hpq_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (SW),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign w_acc      = i_in.valid && (r_state == S_IDLE);
    assign w_load     = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    assign w_left   = IW'({r_pos, 1'b1});
    assign w_right  = w_left + IW'(1);
    assign w_cnt_x  = IW'(r_cnt);

    // sift-down compare unit: ties keep the moving key, then the left child
    assign w_pick_l = r_key > r_lval;
    assign w_best   = w_pick_l ? r_lval : r_key;
    assign w_pick_r = r_rvalid && (w_best > w_rdata);

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_pos    = r_pos;
        n_par    = r_par;
        n_key    = r_key;
        n_lval   = r_lval;
        n_rvalid = r_rvalid;
        n_status = r_status;
        n_top    = r_top;
        w_we     = 1'b0;
        w_waddr  = r_pos;
        w_wdata  = r_key;
        w_raddr  = '0;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_status = ST_DONE;
                    n_state  = S_TOP_RD;
                    case (i_in.operation)
                        OP_INSERT: begin
                            if (r_cnt == CW'(CAPACITY)) begin
                                n_status = ST_FULL;
                            end else begin
                                n_key   = i_in.key[SW-1:0];
                                n_pos   = r_cnt[AW-1:0];
                                n_cnt   = r_cnt + CW'(1);
                                n_state = S_UP_RD;
                            end
                        end
                        OP_REMOVE: begin
                            if (r_cnt == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_cnt   = r_cnt - CW'(1);
                                w_raddr = n_cnt[AW-1:0];
                                if (n_cnt != '0) begin
                                    n_state = S_DN_LAST;
                                end
                            end
                        end
                        default: begin
                            if (r_cnt == '0) begin
                                n_status = ST_EMPTY;
                            end
                        end
                    endcase
                end
            end
            S_UP_RD: begin
                if (r_pos == '0) begin
                    w_we    = 1'b1;
                    n_state = S_TOP_RD;
                end else begin
                    n_par   = AW'((r_pos - AW'(1)) >> 1);
                    w_raddr = n_par;
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                w_we = 1'b1;
                if (w_rdata > r_key) begin
                    w_wdata = w_rdata;
                    n_pos   = r_par;
                    n_state = S_UP_RD;
                end else begin
                    n_state = S_TOP_RD;
                end
            end
            S_DN_LAST: begin
                n_key   = w_rdata;
                n_pos   = '0;
                n_state = S_DN_RDL;
            end
            S_DN_RDL: begin
                if (w_left >= w_cnt_x) begin
                    w_we    = 1'b1;
                    n_state = S_TOP_RD;
                end else begin
                    w_raddr = w_left[AW-1:0];
                    n_state = S_DN_RDR;
                end
            end
            S_DN_RDR: begin
                n_lval   = w_rdata;
                n_rvalid = w_right < w_cnt_x;
                w_raddr  = w_right[AW-1:0];
                n_state  = S_DN_CMP;
            end
            S_DN_CMP: begin
                w_we    = 1'b1;
                n_state = S_DN_RDL;
                if (w_pick_r) begin
                    w_wdata = w_rdata;
                    n_pos   = w_right[AW-1:0];
                end else if (w_pick_l) begin
                    w_wdata = r_lval;
                    n_pos   = w_left[AW-1:0];
                end else begin
                    n_state = S_TOP_RD;
                end
            end
            S_TOP_RD: begin
                w_raddr = '0;
                n_state = S_TOP_CAP;
            end
            S_TOP_CAP: begin
                n_top   = (r_cnt != '0) ? KEY_W'(w_rdata) : '0;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_par    <= n_par;
        r_key    <= n_key;
        r_lval   <= n_lval;
        r_rvalid <= n_rvalid;
        r_status <= n_status;
        r_top    <= n_top;
        if (w_load) begin
            r_out_status <= r_status;
            r_out_key    <= r_top;
            r_out_tv     <= (r_cnt != '0);
            r_out_cnt    <= r_cnt;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.status    = r_out_status;
    assign o_out.top_key   = r_out_key;
    assign o_out.top_valid = r_out_tv;
    assign o_out.count     = r_out_cnt;
endmodule
`default_nettype wire

// File: sv/hpq_mem.sv
// heap storage: one write port and one read port with registered read data
`default_nettype none
module hpq_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32,
    parameter int AW    = 10
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: sim/heap_result_checker.sv
// watches both queue channels, tracks the heap contents and checks every result transfer
`default_nettype none
module heap_result_checker #(
    parameter int CAPACITY = hpq_pkg::DEF_CAPACITY,
    parameter int KEY_BITS = hpq_pkg::DEF_KEY_BITS,
    parameter int CNT_W    = 11
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    hpq_req_if        i_req,
    hpq_res_if        i_res,
    output int        o_fail_count,
    output int        o_pending
);
    import hpq_pkg::*;

    localparam int KB = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - KB);

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [KEY_W-1:0] top_key;
        logic             top_valid;
        logic [CNT_W-1:0] count;
    } t_heap_result;

    logic [KEY_W-1:0] heap_mem [CAPACITY];
    int unsigned      heap_size = 0;
    t_heap_result     predicted_results [$];
    int               fail_total = 0;
    int               result_idx = 0;

    function automatic t_heap_result apply_request(input logic [OP_W-1:0] op,
                                                   input logic [KEY_W-1:0] raw_key);
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] tmp;
        int unsigned      pos;
        int unsigned      parent;
        int unsigned      best;
        int unsigned      left;
        int unsigned      right;
        t_heap_result     r;
        k = raw_key & KEY_MASK;
        r.status = ST_DONE;
        case (op)
            OP_INSERT: begin
                if (heap_size >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    heap_mem[heap_size] = k;
                    pos = heap_size;
                    while (pos > 0) begin
                        parent = (pos - 1) / 2;
                        if (heap_mem[parent] <= heap_mem[pos])
                            break;
                        tmp = heap_mem[parent];
                        heap_mem[parent] = heap_mem[pos];
                        heap_mem[pos] = tmp;
                        pos = parent;
                    end
                    heap_size++;
                end
            end
            OP_REMOVE: begin
                if (heap_size == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    heap_size--;
                    heap_mem[0] = heap_mem[heap_size];
                    pos = 0;
                    while (pos < heap_size) begin
                        best = pos;
                        left = 2 * pos + 1;
                        right = left + 1;
                        if (left < heap_size && heap_mem[best] > heap_mem[left])
                            best = left;
                        if (right < heap_size && heap_mem[best] > heap_mem[right])
                            best = right;
                        if (best == pos)
                            break;
                        tmp = heap_mem[best];
                        heap_mem[best] = heap_mem[pos];
                        heap_mem[pos] = tmp;
                        pos = best;
                    end
                end
            end
            default: begin
                // peek and the unused code leave the heap alone
                if (heap_size == 0)
                    r.status = ST_EMPTY;
            end
        endcase
        r.top_valid = (heap_size > 0);
        r.top_key = (heap_size > 0) ? heap_mem[0] : '0;
        r.count = CNT_W'(heap_size);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [KEY_W-1:0] want,
                                   input logic [KEY_W-1:0] got);
        if (fail_total < 40)
            $display("[%0t] result %0d: %s expected %h got %h",
                     $time, result_idx, what, want, got);
        fail_total++;
    endtask

    always @(posedge i_clk) begin : monitor
        t_heap_result want;
        if (!i_rst_n) begin
            heap_size = 0;
            predicted_results.delete();
        end else begin
            if (i_req.valid && i_req.ready)
                predicted_results.push_back(apply_request(i_req.operation, i_req.key));
            if (i_res.valid && i_res.ready) begin
                result_idx++;
                if (predicted_results.size() == 0) begin
                    report_mismatch("result with none outstanding, top_key", '0,
                                    i_res.top_key);
                end else begin
                    want = predicted_results.pop_front();
                    if (i_res.status !== want.status)
                        report_mismatch("status", KEY_W'(want.status),
                                        KEY_W'(i_res.status));
                    if (i_res.top_key !== want.top_key)
                        report_mismatch("top_key", want.top_key, i_res.top_key);
                    if (i_res.top_valid !== want.top_valid)
                        report_mismatch("top_valid", KEY_W'(want.top_valid),
                                        KEY_W'(i_res.top_valid));
                    if (i_res.count !== want.count)
                        report_mismatch("count", KEY_W'(want.count), KEY_W'(i_res.count));
                end
            end
        end
        o_pending <= predicted_results.size();
        o_fail_count <= fail_total;
    end

endmodule
`default_nettype wire

// File: sim/min_heap_priority_queue_tb.sv
// testbench top for the min-heap priority queue: clock, reset, request stimulus and verdict
`default_nettype none
module min_heap_priority_queue_tb;
    import hpq_pkg::*;

    localparam int CAPACITY    = DEF_CAPACITY;
    localparam int KEY_BITS    = DEF_KEY_BITS;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int TOTAL_ITEMS = 1950;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n;

    hpq_req_if                    req_ch ();
    hpq_res_if #(.CNT_W(CNT_W))   res_ch ();

    int fail_count;
    int pending;

    int sent = 0;
    int level = 0;
    int peak_level = 0;
    int burst_left = 0;
    int n_insert = 0;
    int n_remove = 0;
    int n_peek = 0;
    int n_unused = 0;
    int n_dropped = 0;
    int n_empty = 0;

    logic [15:0] ready_word;
    int          ready_pos;

    min_heap_priority_queue #(
        .CAPACITY(CAPACITY),
        .KEY_BITS(KEY_BITS)
    ) uut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (req_ch),
        .o_out  (res_ch)
    );

    heap_result_checker #(
        .CAPACITY(CAPACITY),
        .KEY_BITS(KEY_BITS),
        .CNT_W   (CNT_W)
    ) checker_i (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req       (req_ch),
        .i_res       (res_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // result side stalls follow 16-bit ready patterns of varying density, applied bit by bit
    always @(posedge clk) begin
        if (!rst_n) begin
            res_ch.ready <= 1'b0;
            ready_pos <= 0;
            ready_word = '1;
        end else begin
            if (ready_pos == 0) begin
                case ($urandom_range(0, 3))
                    0: ready_word = '1;
                    1: ready_word = 16'($urandom);
                    2: ready_word = 16'($urandom & $urandom);
                    default: ready_word = 16'h8000;
                endcase
            end
            res_ch.ready <= ready_word[ready_pos];
            ready_pos <= (ready_pos + 1) % 16;
        end
    end

    function automatic logic [KEY_W-1:0] pick_key();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 3)
            return KEY_W'($urandom_range(0, 15));
        if (sel == 3) begin
            case ($urandom_range(0, 3))
                0: return '0;
                1: return '1;
                2: return KEY_W'(1) << $urandom_range(0, KEY_W - 1);
                default: return ~(KEY_W'(1) << $urandom_range(0, KEY_W - 1));
            endcase
        end
        return KEY_W'($urandom);
    endfunction

    function automatic logic [OP_W-1:0] pick_op(input int w_insert, input int w_remove);
        int r;
        r = $urandom_range(0, 99);
        if (r < w_insert)
            return OP_INSERT;
        if (r < w_insert + w_remove)
            return OP_REMOVE;
        return ($urandom_range(0, 2) == 0) ? OP_UNUSED : OP_PEEK;
    endfunction

    task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_ch.valid <= 1'b1;
        req_ch.operation <= op;
        req_ch.key <= key;
        do @(posedge clk); while (!req_ch.ready);
        sent++;
        case (op)
            OP_INSERT: begin
                n_insert++;
                if (level >= CAPACITY)
                    n_dropped++;
                else
                    level++;
            end
            OP_REMOVE: begin
                n_remove++;
                if (level == 0)
                    n_empty++;
                else
                    level--;
            end
            default: begin
                if (op == OP_UNUSED)
                    n_unused++;
                else
                    n_peek++;
                if (level == 0)
                    n_empty++;
            end
        endcase
        if (level > peak_level)
            peak_level = level;
    endtask

    initial begin
        logic [OP_W-1:0]  dir_op  [25];
        logic [KEY_W-1:0] dir_key [25];
        dir_op = '{OP_PEEK, OP_REMOVE, OP_UNUSED,
                   OP_INSERT, OP_INSERT, OP_INSERT, OP_PEEK, OP_UNUSED,
                   OP_INSERT, OP_INSERT, OP_INSERT, OP_INSERT,
                   OP_INSERT, OP_INSERT, OP_INSERT,
                   OP_REMOVE, OP_REMOVE, OP_REMOVE, OP_REMOVE, OP_REMOVE, OP_REMOVE,
                   OP_REMOVE, OP_REMOVE, OP_REMOVE, OP_REMOVE};
        dir_key = '{32'h0, 32'hFFFF_FFFF, 32'h1234_5678,
                    32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'hA5A5_A5A5,
                    32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
                    32'd5, 32'd5, 32'd5,
                    32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};

        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.operation = OP_PEEK;
        req_ch.key = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty heap, key extremes, ties, draining back to empty
        for (int i = 0; i < 25; i++)
            send_request(dir_op[i], dir_key[i]);

        // mixed traffic at low occupancy
        repeat (300)
            send_request(pick_op(46, 36), pick_key());

        // fill to capacity, then push against the full heap
        while (level < CAPACITY)
            send_request(pick_op(92, 4), pick_key());
        repeat (24)
            send_request(pick_op(85, 3), pick_key());

        // mostly drain for the rest
        while (sent < TOTAL_ITEMS)
            send_request(pick_op(10, 85), pick_key());

        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (48) @(posedge clk);

        $display("%0d requests: %0d inserts, %0d removes, %0d peeks, %0d with the unused code",
                 sent, n_insert, n_remove, n_peek, n_unused);
        $display("occupancy peaked at %0d of %0d; %0d inserts dropped while full, %0d on empty",
                 peak_level, CAPACITY, n_dropped, n_empty);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #4000000;
        $display("timeout with %0d results outstanding", pending);
        $display("TEST FAILED");
        $finish;
    end

endmodule
`default_nettype wire
